// ----- design/box_filter_downsampler_macros.svh -----
// Assertion macros shared by the checker of the box filter downsampler.
`ifndef BOX_FILTER_DOWNSAMPLER_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk and silent while rst is high.
`define BFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box filter downsampler check failed");

// Next-cycle implication, sampled on clk and silent while rst is high.
`define BFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box filter downsampler check failed");

`endif

// ----- design/bfd_pkg.sv -----
// Shared types, constants and lookup functions of the box filter downsampler.
package bfd_pkg;

  localparam int PIX_W      = 32;
  localparam int POS_W      = 11;
  localparam int DIM_W      = 12;
  localparam int FACTOR_W   = 4;
  localparam int CIB_W      = 3;
  localparam int CH_W       = 14;
  localparam int SUM_DEPTH  = 1024;
  localparam int SUM_AW     = $clog2(SUM_DEPTH);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_FACTOR = 8;
  localparam int MAX_DIM    = 2048;
  localparam int RECF_W     = 16;
  localparam int RECF_SHIFT = 15;
  localparam int RECA_W     = 19;
  localparam int RECA_SHIFT = 20;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [1:0] REG_FACTOR       = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    logic [FACTOR_W-1:0] f;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
  } cfg_t;

  // Block position of the pixel being accepted.
  typedef struct packed {
    logic             hit;
    logic             first;
    logic             last;
    logic             f1;
    logic             fend;
    logic [POS_W-1:0] bcol;
    logic [POS_W-1:0] brow;
  } pos_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } sum_t;

  typedef struct packed {
    logic [PIX_W-1:0] color;
    logic [POS_W-1:0] out_column;
    logic [POS_W-1:0] out_row;
    logic             frame_end;
  } res_t;

  function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
    logic [FACTOR_W-1:0] e;
    e = f;
    if (f == '0) e = FACTOR_W'(1);
    else if (f > FACTOR_W'(MAX_FACTOR)) e = FACTOR_W'(MAX_FACTOR);
    return e;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    e = v;
    if (v == '0) e = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) e = DIM_W'(MAX_DIM);
    return e;
  endfunction

  // ceil(2^15 / f): exact floor division of any 12-bit value by f.
  function automatic logic [RECF_W-1:0] recip_factor(input logic [FACTOR_W-1:0] f);
    logic [RECF_W-1:0] r;
    case (f)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6554;
      4'd6:    r = 16'd5462;
      4'd7:    r = 16'd4682;
      4'd8:    r = 16'd4096;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

  // ceil(2^20 / f^2): exact floor division of any 14-bit sum by the block area.
  function automatic logic [RECA_W-1:0] recip_area(input logic [FACTOR_W-1:0] f);
    logic [RECA_W-1:0] r;
    case (f)
      4'd2:    r = 19'd262144;
      4'd3:    r = 19'd116509;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd41944;
      4'd6:    r = 19'd29128;
      4'd7:    r = 19'd21400;
      4'd8:    r = 19'd16384;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/bfd_ifs.sv -----
// Valid/ready stream interfaces for the pixel input and the result output.
interface bfd_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [bfd_pkg::PIX_W-1:0] pixel;
  logic                     frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface bfd_result_if;
  logic                      valid;
  logic                      ready;
  logic [bfd_pkg::PIX_W-1:0] color;
  logic [bfd_pkg::POS_W-1:0] out_column;
  logic [bfd_pkg::POS_W-1:0] out_row;
  logic                      frame_end;

  modport source (output valid, output color, output out_column, output out_row,
                  output frame_end, input ready);
  modport sink (input valid, input color, input out_column, input out_row,
                input frame_end, output ready);
endinterface

// ----- design/bfd_position.sv -----
// Position counters and the sequencer that rederives block positions after configuration.
module bfd_position (
  input  logic            clk,
  input  logic            rst,
  input  bfd_pkg::cfg_t   cfg,
  input  logic            restart,
  input  logic            accept,
  input  logic            frame_start,
  output bfd_pkg::pos_t   pos,
  output logic            ready
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_REM = 3'b100
  } seq_state_t;

  seq_state_t state;
  logic [1:0] step;

  logic [bfd_pkg::POS_W-1:0] col, row, bcol, brow;
  logic [bfd_pkg::CIB_W-1:0] cib, rib;
  logic [bfd_pkg::DIM_W-1:0] bw, bh;

  logic [bfd_pkg::POS_W-1:0] c, r, bc, br;
  logic [bfd_pkg::CIB_W-1:0] ci, ri;

  logic [bfd_pkg::POS_W-1:0] col_next, row_next, bcol_next, brow_next;
  logic [bfd_pkg::CIB_W-1:0] cib_next, rib_next;

  logic [bfd_pkg::DIM_W-1:0]   num;
  logic [bfd_pkg::RECF_W-1:0]  recf;
  logic [27:0]                 dprod;
  logic [12:0]                 quo;
  logic [14:0]                 cprod, rprod;

  // A frame start places the pixel at the origin before anything else.
  always_comb begin
    if (frame_start) begin
      c  = '0;
      r  = '0;
      ci = '0;
      ri = '0;
      bc = '0;
      br = '0;
    end else begin
      c  = col;
      r  = row;
      ci = cib;
      ri = rib;
      bc = bcol;
      br = brow;
    end
  end

  always_comb begin
    pos.hit   = (bfd_pkg::DIM_W'(c) < cfg.w) && (bfd_pkg::DIM_W'(r) < cfg.h) &&
                (bfd_pkg::DIM_W'(bc) < bw) && (bfd_pkg::DIM_W'(br) < bh);
    pos.first = (ci == '0) && (ri == '0);
    pos.last  = (bfd_pkg::FACTOR_W'(ci) == cfg.f - 4'd1) &&
                (bfd_pkg::FACTOR_W'(ri) == cfg.f - 4'd1);
    pos.f1    = (cfg.f == 4'd1);
    pos.fend  = (bfd_pkg::DIM_W'(bc) + 12'd1 == bw) && (bfd_pkg::DIM_W'(br) + 12'd1 == bh);
    pos.bcol  = bc;
    pos.brow  = br;
  end

  always_comb begin
    col_next  = c + 11'd1;
    row_next  = r;
    cib_next  = ci + 3'd1;
    rib_next  = ri;
    bcol_next = bc;
    brow_next = br;
    if (bfd_pkg::FACTOR_W'(ci) + 4'd1 == cfg.f) begin
      cib_next  = '0;
      bcol_next = bc + 11'd1;
    end
    if (bfd_pkg::DIM_W'(c) + 12'd1 >= cfg.w) begin
      col_next  = '0;
      cib_next  = '0;
      bcol_next = '0;
      if (bfd_pkg::DIM_W'(r) + 12'd1 >= cfg.h) begin
        row_next  = '0;
        rib_next  = '0;
        brow_next = '0;
      end else begin
        row_next = r + 11'd1;
        if (bfd_pkg::FACTOR_W'(ri) + 4'd1 == cfg.f) begin
          rib_next  = '0;
          brow_next = br + 11'd1;
        end else begin
          rib_next = ri + 3'd1;
        end
      end
    end
  end

  // One shared reciprocal multiplier divides column, row, width and height by the factor.
  always_comb begin
    case (step)
      2'd0:    num = bfd_pkg::DIM_W'(col);
      2'd1:    num = bfd_pkg::DIM_W'(row);
      2'd2:    num = cfg.w;
      default: num = cfg.h;
    endcase
    recf  = bfd_pkg::recip_factor(cfg.f);
    dprod = num * recf;
    quo   = dprod[27:bfd_pkg::RECF_SHIFT];
    cprod = bcol * cfg.f;
    rprod = brow * cfg.f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DIV;
      step  <= '0;
      col   <= '0;
      row   <= '0;
      cib   <= '0;
      rib   <= '0;
      bcol  <= '0;
      brow  <= '0;
      bw    <= '0;
      bh    <= '0;
    end else if (restart) begin
      state <= ST_DIV;
      step  <= '0;
    end else begin
      case (state)
        ST_DIV: begin
          case (step)
            2'd0:    bcol <= quo[bfd_pkg::POS_W-1:0];
            2'd1:    brow <= quo[bfd_pkg::POS_W-1:0];
            2'd2:    bw   <= quo[bfd_pkg::DIM_W-1:0];
            default: bh   <= quo[bfd_pkg::DIM_W-1:0];
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) state <= ST_REM;
        end
        ST_REM: begin
          cib   <= bfd_pkg::CIB_W'(col - cprod[bfd_pkg::POS_W-1:0]);
          rib   <= bfd_pkg::CIB_W'(row - rprod[bfd_pkg::POS_W-1:0]);
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (accept) begin
            col  <= col_next;
            row  <= row_next;
            cib  <= cib_next;
            rib  <= rib_next;
            bcol <= bcol_next;
            brow <= brow_next;
          end
        end
        default: state <= ST_DIV;
      endcase
    end
  end

  assign ready = (state == ST_RUN);

endmodule

// ----- design/box_filter_downsampler.sv -----
// Top level of the box filter downsampler: configuration, accumulator line and output queue.
//
//   channel   | role    | payload
//   ----------+---------+---------------------------------------------
//   pixel_ch  | sink    | pixel[31:0], frame_start
//   result_ch | source  | color[31:0], out_column[10:0], out_row[10:0], frame_end
//   apb       | slave   | factor, frame_width, frame_height at 0x0, 0x4, 0x8
//
// A pixel is accepted every cycle while the sequencer runs and the output queue has room;
// a block's result enters the queue after the accumulator read, read-modify-write and multiply.
// The accumulator line is a 1024 x 42 synchronous memory with a registered read;
// back-to-back requests to the same entry are served from a forwarding register.
// After reset and after every register write the position sequencer rederives block positions,
// during which no request is accepted.
// A stalled result side fills the eight-entry queue and then holds off input requests.
module box_filter_downsampler (
  input  logic                clk,
  input  logic                rst,
  bfd_pixel_if.sink           pixel_ch,
  bfd_result_if.source        result_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [bfd_pkg::FACTOR_W-1:0] factor;
  logic [bfd_pkg::DIM_W-1:0]    frame_width, frame_height;
  bfd_pkg::cfg_t                cfg;
  logic                         cfg_wr;

  bfd_pkg::pos_t pos;
  logic          pos_ready;
  logic          accept;

  // Stage 1: read-modify-write of the accumulator entry.
  logic                        s1_valid;
  bfd_pkg::pos_t               s1_pos;
  logic [bfd_pkg::PIX_W-1:0]   s1_pix;
  logic                        s1_fwd;
  bfd_pkg::sum_t               fwd_data, rd_data, old_sum, new_sum;
  logic                        s1_wr, s1_res;
  logic [bfd_pkg::CH_W-1:0]    px_r, px_g, px_b;

  bfd_pkg::sum_t sum_mem [0:bfd_pkg::SUM_DEPTH-1];

  // Stage 2: division by the block area.
  logic                        s2_valid;
  bfd_pkg::sum_t               s2_sum;
  logic [bfd_pkg::PIX_W-1:0]   s2_pix;
  logic                        s2_f1, s2_fend;
  logic [bfd_pkg::POS_W-1:0]   s2_bcol, s2_brow;
  logic [bfd_pkg::RECA_W-1:0]  reca;
  logic [32:0]                 prod_r, prod_g, prod_b;
  bfd_pkg::res_t               s2_res;

  // Output queue.
  bfd_pkg::res_t               fifo_mem [0:bfd_pkg::FIFO_DEPTH-1];
  logic [bfd_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [bfd_pkg::FIFO_CW-1:0] count;
  logic [bfd_pkg::FIFO_CW-1:0] pending;
  logic                        pop;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor       <= 4'd2;
      frame_width  <= 12'd640;
      frame_height <= 12'd480;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bfd_pkg::REG_FACTOR:       factor       <= pwdata[bfd_pkg::FACTOR_W-1:0];
        bfd_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[bfd_pkg::DIM_W-1:0];
        bfd_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[bfd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bfd_pkg::REG_FACTOR:       prdata = 32'(factor);
      bfd_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      bfd_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.f = bfd_pkg::eff_factor(factor);
    cfg.w = bfd_pkg::clamp_dim(frame_width);
    cfg.h = bfd_pkg::clamp_dim(frame_height);
  end

  bfd_position u_position (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (cfg_wr),
    .accept      (accept),
    .frame_start (pixel_ch.frame_start),
    .pos         (pos),
    .ready       (pos_ready)
  );

  // Every request in flight may still need a queue slot.
  assign pending = count + bfd_pkg::FIFO_CW'(s1_res) + bfd_pkg::FIFO_CW'(s2_valid);
  assign pixel_ch.ready = pos_ready && (pending < bfd_pkg::FIFO_CW'(bfd_pkg::FIFO_DEPTH));
  assign accept = pixel_ch.valid && pixel_ch.ready;

  // Accumulator memory.
  always_ff @(posedge clk) begin
    if (accept) rd_data <= sum_mem[pos.bcol[bfd_pkg::SUM_AW-1:0]];
    if (s1_wr) sum_mem[s1_pos.bcol[bfd_pkg::SUM_AW-1:0]] <= new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // When the previous request writes the entry this one reads, the read sees stale data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos;
      s1_pix   <= pixel_ch.pixel;
      s1_fwd   <= s1_wr && (s1_pos.bcol[bfd_pkg::SUM_AW-1:0] == pos.bcol[bfd_pkg::SUM_AW-1:0]);
      fwd_data <= new_sum;
    end
  end

  always_comb begin
    px_r    = bfd_pkg::CH_W'(s1_pix[31:24]);
    px_g    = bfd_pkg::CH_W'(s1_pix[23:16]);
    px_b    = bfd_pkg::CH_W'(s1_pix[15:8]);
    old_sum = s1_fwd ? fwd_data : rd_data;
    if (s1_pos.first) begin
      new_sum.r = px_r;
      new_sum.g = px_g;
      new_sum.b = px_b;
    end else begin
      new_sum.r = old_sum.r + px_r;
      new_sum.g = old_sum.g + px_g;
      new_sum.b = old_sum.b + px_b;
    end
    s1_wr  = s1_valid && s1_pos.hit && !s1_pos.f1;
    s1_res = s1_valid && s1_pos.hit && (s1_pos.f1 || s1_pos.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_res) begin
      s2_sum  <= new_sum;
      s2_pix  <= s1_pix;
      s2_f1   <= s1_pos.f1;
      s2_fend <= s1_pos.fend;
      s2_bcol <= s1_pos.bcol;
      s2_brow <= s1_pos.brow;
    end
  end

  always_comb begin
    reca   = bfd_pkg::recip_area(cfg.f);
    prod_r = s2_sum.r * reca;
    prod_g = s2_sum.g * reca;
    prod_b = s2_sum.b * reca;
    if (s2_f1) begin
      s2_res.color = s2_pix;
    end else begin
      s2_res.color = {prod_r[27:bfd_pkg::RECA_SHIFT], prod_g[27:bfd_pkg::RECA_SHIFT],
                      prod_b[27:bfd_pkg::RECA_SHIFT], bfd_pkg::ALPHA_OPAQUE};
    end
    s2_res.out_column = s2_bcol;
    s2_res.out_row    = s2_brow;
    s2_res.frame_end  = s2_fend;
  end

  // Output queue.
  assign result_ch.valid = (count != '0);
  assign pop = result_ch.valid && result_ch.ready;
  assign result_ch.color      = fifo_mem[rd_ptr].color;
  assign result_ch.out_column = fifo_mem[rd_ptr].out_column;
  assign result_ch.out_row    = fifo_mem[rd_ptr].out_row;
  assign result_ch.frame_end  = fifo_mem[rd_ptr].frame_end;

  always_ff @(posedge clk) begin
    if (s2_valid) fifo_mem[wr_ptr] <= s2_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s2_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + bfd_pkg::FIFO_CW'(s2_valid) - bfd_pkg::FIFO_CW'(pop);
    end
  end

endmodule

// ----- design/bfd_checker.sv -----
// Port-level checker of the box filter downsampler and its bind statement.
`include "box_filter_downsampler_macros.svh"

module bfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_color,
  input logic [10:0] out_column,
  input logic [10:0] out_row,
  input logic        out_frame_end,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // A result that is not taken stays offered with the same contents.
  `BFD_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_color) && $stable(out_column) && $stable(out_row) && $stable(out_frame_end))

  // A register write restarts the position sequencer, so no request is taken next.
  `BFD_ASSERT_NEXT(a_cfg_blocks_input, psel && penable && pwrite, !in_ready)

  // Block positions are still being derived right after reset.
  `BFD_ASSERT_IMPL(a_reset_blocks_input, $fell(rst), !in_ready)

endmodule

bind box_filter_downsampler bfd_checker u_bfd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pixel_ch.ready),
  .out_valid     (result_ch.valid),
  .out_ready     (result_ch.ready),
  .out_color     (result_ch.color),
  .out_column    (result_ch.out_column),
  .out_row       (result_ch.out_row),
  .out_frame_end (result_ch.frame_end),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite)
);
